/* rtl/hsl_pkg.sv */
package hsl_pkg;

   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_ITERS    = 16;
   localparam int ATAN_LEN        = 24;
   localparam int ITER_W          = $clog2(CORDIC_ITERS + 1);
   // CORDIC x/y grow by ~1.65 and shifts of 33-bit diffs: 36 bits suffice
   localparam int CORDIC_W        = 36;

   // pi rounded to the angle format
   localparam logic signed [15:0] PI_Q = 16'((64'd31415926 * (64'd1 << ANGLE_FRAC_BITS)
                                              + 64'd5000000) / 64'd10000000);
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic [19:0] MICRO = 20'd1000000;
   // ceil(2^43 / 15625): exact floor division by 15625 for inputs below 2^29
   localparam logic [29:0] RECIP_15625 = 30'd562949954;

   localparam logic [19:0] MIN_DIR_RESET = 20'd6554;
   localparam logic [14:0] MAX_RATE_RESET = 15'd25736;
   localparam logic [19:0] DEF_DT_RESET = 20'd20000;

   localparam logic [1:0] REG_MIN_DIR = 2'd0;
   localparam logic [1:0] REG_MAX_RATE = 2'd1;
   localparam logic [1:0] REG_DEF_DT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_CORDIC,
      ST_ROUND,
      ST_STEP,
      ST_LIMIT,
      ST_DIVIDE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic square;
      logic cordic_step;
      logic round;
      logic step;
      logic limit;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
      logic use_divide;
   } status_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0: r = 30'd843314856;
         5'd1: r = 30'd497837829;
         5'd2: r = 30'd263043836;
         5'd3: r = 30'd133525158;
         5'd4: r = 30'd67021686;
         5'd5: r = 30'd33543515;
         5'd6: r = 30'd16775850;
         5'd7: r = 30'd8388437;
         5'd8: r = 30'd4194282;
         5'd9: r = 30'd2097149;
         5'd10: r = 30'd1048575;
         5'd11: r = 30'd524287;
         5'd12: r = 30'd262143;
         5'd13: r = 30'd131071;
         5'd14: r = 30'd65535;
         5'd15: r = 30'd32767;
         5'd16: r = 30'd16383;
         5'd17: r = 30'd8191;
         5'd18: r = 30'd4095;
         5'd19: r = 30'd2047;
         5'd20: r = 30'd1023;
         5'd21: r = 30'd511;
         5'd22: r = 30'd255;
         5'd23: r = 30'd127;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/hsl_ctrl.sv */
module hsl_ctrl import hsl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_CORDIC;
         ST_CORDIC: if (status.cordic_done) state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_STEP;
         ST_STEP:   state_in = ST_LIMIT;
         ST_LIMIT:  state_in = status.use_divide ? ST_DIVIDE : ST_FINISH;
         ST_DIVIDE: if (status.div_done) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DIFF:   cmd.diff = 1'b1;
         ST_SQUARE: cmd.square = 1'b1;
         ST_CORDIC: cmd.cordic_step = 1'b1;
         ST_ROUND:  cmd.round = 1'b1;
         ST_STEP:   cmd.step = 1'b1;
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            cmd.div_start = status.use_divide;
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         ST_OUTPUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

/* rtl/hsl_datapath.sv */
module hsl_datapath import hsl_pkg::*; (
   input  logic               clock,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [31:0] ahead_x,
   input  logic signed [31:0] ahead_y,
   input  logic signed [31:0] ahead_z,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic signed [31:0] pos_z,
   input  logic [19:0]        elapsed_us,
   input  logic [19:0]        min_dir_length,
   input  logic [14:0]        max_yaw_rate,
   input  logic [19:0]        default_dt_us,
   input  logic               clear,
   output logic signed [15:0] yaw,
   output logic signed [15:0] yaw_rate
);

   logic signed [31:0] ax_ff, ay_ff, az_ff, px_ff, py_ff, pz_ff;
   logic [19:0] dt_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic far_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff;
   logic signed [CORDIC_W-1:0] cz_ff;
   logic [ITER_W-1:0] iter_ff;
   logic signed [15:0] target_ff, diff_ff, prev_yaw_ff, prev_rate_ff;
   logic [34:0] lim_ff;
   logic signed [16:0] yaw_new_ff;
   logic signed [16:0] rate_new_ff;
   logic [34:0] rem_ff;
   logic [34:0] num_ff;
   logic [34:0] quot_ff;
   logic [5:0] dcnt_ff;

   // direction test
   logic [32:0] abx, aby, abz;
   logic [41:0] sq_sum;
   logic [39:0] thr_sq;
   logic big;
   always_comb begin
      abx = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      aby = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      abz = dz_ff[32] ? 33'(-dz_ff) : 33'(dz_ff);
      big = (abx[32:20] != '0) || (aby[32:20] != '0) || (abz[32:20] != '0);
      sq_sum = 42'(abx[19:0] * abx[19:0]) + 42'(aby[19:0] * aby[19:0])
             + 42'(abz[19:0] * abz[19:0]);
      thr_sq = min_dir_length * min_dir_length;
   end

   // one CORDIC iteration
   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [CORDIC_W-1:0] atan_e;
   always_comb begin
      xs = cx_ff >>> iter_ff;
      ys = cy_ff >>> iter_ff;
      atan_e = CORDIC_W'(signed'({1'b0, atan_q30(5'(iter_ff))}));
   end
   assign status.cordic_done = (iter_ff == ITER_W'(CORDIC_ITERS - 1));

   logic signed [CORDIC_W-1:0] zr;
   logic signed [CORDIC_W-1:0] zs;
   always_comb begin
      zr = cz_ff + CORDIC_W'(36'sd1 <<< (29 - ANGLE_FRAC_BITS));
      zs = zr >>> (30 - ANGLE_FRAC_BITS);
   end

   logic signed [16:0] d0;
   logic signed [16:0] dw;
   logic [15:0] adiff;
   always_comb begin
      d0 = 17'(target_ff) - 17'(prev_yaw_ff);
      if (d0 > 17'(PI_Q)) dw = d0 - 17'(2 * PI_Q);
      else if (d0 < -17'(PI_Q)) dw = d0 + 17'(2 * PI_Q);
      else dw = d0;
      adiff = diff_ff[15] ? 16'(-diff_ff) : 16'(diff_ff);
   end

   // clip test on the current step
   logic [34:0] scaled;
   logic clip;
   always_comb begin
      scaled = 35'(adiff * MICRO);
      clip = scaled > lim_ff;
   end

   // lim_ff / 10^6: drop the 2^6 factor, then multiply by the reciprocal of 15625.
   // Only used when clipped, so the quotient is below the step and fits 15 bits.
   logic [58:0] recip_p;
   logic [14:0] step_q;
   logic signed [16:0] ystep;
   always_comb begin
      recip_p = lim_ff[34:6] * RECIP_15625;
      step_q = recip_p[57:43];
      ystep = diff_ff[15] ? (17'(prev_yaw_ff) - 17'(step_q))
                          : (17'(prev_yaw_ff) + 17'(step_q));
   end
   assign status.use_divide = !clip;
   assign status.div_done = (dcnt_ff == 6'd34);

   logic [35:0] rtrial;
   always_comb rtrial = {rem_ff, num_ff[34]} - {16'd0, dt_ff};

   logic signed [16:0] yw;
   logic signed [17:0] ysum, rsum;
   always_comb begin
      if (yaw_new_ff > 17'(PI_Q)) yw = yaw_new_ff - 17'(2 * PI_Q);
      else if (yaw_new_ff < -17'(PI_Q)) yw = yaw_new_ff + 17'(2 * PI_Q);
      else yw = yaw_new_ff;
      ysum = 18'(yw) + 18'(prev_yaw_ff);
      rsum = 18'(rate_new_ff) + 18'(prev_rate_ff);
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         prev_yaw_ff <= '0;
         prev_rate_ff <= '0;
      end else if (cmd.finish) begin
         prev_yaw_ff <= ysum[16:1];
         prev_rate_ff <= rsum[16:1];
      end
      if (cmd.load) begin
         ax_ff <= ahead_x; ay_ff <= ahead_y; az_ff <= ahead_z;
         px_ff <= pos_x; py_ff <= pos_y; pz_ff <= pos_z;
         if (elapsed_us != '0) dt_ff <= elapsed_us;
         else if (default_dt_us != '0) dt_ff <= default_dt_us;
         else dt_ff <= 20'd1;
      end
      if (cmd.diff) begin
         dx_ff <= 33'(ax_ff) - 33'(px_ff);
         dy_ff <= 33'(ay_ff) - 33'(py_ff);
         dz_ff <= 33'(az_ff) - 33'(pz_ff);
      end
      if (cmd.square) begin
         far_ff <= big || (sq_sum > 42'(thr_sq));
         iter_ff <= '0;
         if (dx_ff[32]) begin
            if (!dy_ff[32]) begin
               cx_ff <= CORDIC_W'(dy_ff); cy_ff <= -CORDIC_W'(dx_ff);
               cz_ff <= HALF_PI_Q30;
            end else begin
               cx_ff <= -CORDIC_W'(dy_ff); cy_ff <= CORDIC_W'(dx_ff);
               cz_ff <= -HALF_PI_Q30;
            end
         end else begin
            cx_ff <= CORDIC_W'(dx_ff); cy_ff <= CORDIC_W'(dy_ff); cz_ff <= '0;
         end
      end
      if (cmd.cordic_step) begin
         iter_ff <= iter_ff + 1'b1;
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs; cz_ff <= cz_ff + atan_e;
         end else begin
            cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs; cz_ff <= cz_ff - atan_e;
         end
      end
      if (cmd.round) begin
         if (!far_ff) target_ff <= prev_yaw_ff;
         else if (dx_ff == '0 && dy_ff == '0) target_ff <= '0;
         else if (zs > CORDIC_W'(PI_Q)) target_ff <= PI_Q;
         else if (zs < -CORDIC_W'(PI_Q)) target_ff <= -PI_Q;
         else target_ff <= 16'(zs);
      end
      if (cmd.step) begin
         diff_ff <= 16'(dw);
         lim_ff <= 35'(max_yaw_rate * dt_ff);
      end
      if (cmd.limit) begin
         if (clip) begin
            yaw_new_ff <= ystep;
            rate_new_ff <= diff_ff[15] ? -17'(max_yaw_rate) : 17'(max_yaw_rate);
         end else begin
            yaw_new_ff <= 17'(target_ff);
         end
      end
      if (cmd.div_start) begin
         num_ff <= scaled + 35'(dt_ff >> 1);
         rem_ff <= '0;
         quot_ff <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (dcnt_ff != 6'd35) begin
            dcnt_ff <= dcnt_ff + 1'b1;
            num_ff <= {num_ff[33:0], 1'b0};
            if (!rtrial[35]) begin
               rem_ff <= rtrial[34:0];
               quot_ff <= {quot_ff[33:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[33:0], num_ff[34]};
               quot_ff <= {quot_ff[33:0], 1'b0};
            end
         end
         if (status.div_done) begin
            rate_new_ff <= diff_ff[15] ? -17'({quot_ff[33:0], !rtrial[35]})
                                       : 17'({quot_ff[33:0], !rtrial[35]});
         end
      end
   end

   assign yaw = prev_yaw_ff;
   assign yaw_rate = prev_rate_ff;

endmodule

/* rtl/heading_slew_limiter.sv */
// Heading slew limiter: one result per accepted item, one item at a time.
// An item passes through idle and load, setup, 16 CORDIC atan2 iterations,
// limit, bit-serial rate division, update and output. A clipped step skips
// the divider. The result is held until taken, and a held result holds off
// the input.
module heading_slew_limiter import hsl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_ahead_x,
   input  logic signed [31:0] req_ahead_y,
   input  logic signed [31:0] req_ahead_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [19:0]        req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_yaw,
   output logic signed [15:0] rsp_yaw_rate,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [19:0] min_dir_ff;
   logic [14:0] max_rate_ff;
   logic [19:0] def_dt_ff;
   logic [1:0] reg_idx;
   logic wr;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[3:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dir_ff <= MIN_DIR_RESET;
         max_rate_ff <= MAX_RATE_RESET;
         def_dt_ff <= DEF_DT_RESET;
      end else if (wr) begin
         unique case (reg_idx)
            REG_MIN_DIR:  min_dir_ff <= csr_pwdata[19:0];
            REG_MAX_RATE: max_rate_ff <= csr_pwdata[14:0];
            REG_DEF_DT:   def_dt_ff <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_DIR:  csr_prdata = {12'd0, min_dir_ff};
         REG_MAX_RATE: csr_prdata = {17'd0, max_rate_ff};
         REG_DEF_DT:   csr_prdata = {12'd0, def_dt_ff};
         default:      csr_prdata = '0;
      endcase
   end

   cmd_type cmd;
   status_type status;

   hsl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   hsl_datapath u_dp (
      .clock(clock), .cmd(cmd), .status(status),
      .ahead_x(req_ahead_x), .ahead_y(req_ahead_y), .ahead_z(req_ahead_z),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .elapsed_us(req_elapsed_us),
      .min_dir_length(min_dir_ff), .max_yaw_rate(max_rate_ff),
      .default_dt_us(def_dt_ff), .clear(reset),
      .yaw(rsp_yaw), .yaw_rate(rsp_yaw_rate)
   );

endmodule
